// ----- hw/rtl/sitoa_pkg.sv -----
// Shared types, constants and helpers of the decimal ASCII printer.
package sitoa_pkg;

    localparam int VALUE_W   = 32;
    localparam int SCALE_W   = 8;
    localparam int CHAR_W    = 6;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W     = 4 * NUM_DIGITS;
    localparam int POS_W     = 4;
    localparam int FRAC_W    = 3;
    localparam int STEP_W    = 5;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    localparam logic [SCALE_W-1:0] SCALE_FRAC1 = 8'hFF;
    localparam logic [SCALE_W-1:0] SCALE_FRAC2 = 8'hFE;
    localparam logic [SCALE_W-1:0] SCALE_FRAC3 = 8'hFD;
    localparam logic [SCALE_W-1:0] SCALE_FRAC4 = 8'hFC;
    localparam logic [SCALE_W-1:0] SCALE_FRAC5 = 8'hFB;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 6'd46;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VALUE_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SETUP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic setup;
        logic emit_step;
    } dp_cmd_t;

    typedef struct packed {
        logic conv_done;
        logic out_free;
        logic emit_last;
    } dp_status_t;

    function automatic logic [FRAC_W-1:0] frac_digits(input logic [SCALE_W-1:0] code);
        logic [FRAC_W-1:0] k;
        unique case (code)
            SCALE_FRAC1: k = 3'd1;
            SCALE_FRAC2: k = 3'd2;
            SCALE_FRAC3: k = 3'd3;
            SCALE_FRAC4: k = 3'd4;
            SCALE_FRAC5: k = 3'd5;
            default:     k = 3'd0;
        endcase
        return k;
    endfunction

endpackage

// ----- hw/rtl/scaled_int_to_decimal_ascii.sv -----
// Top level of the signed fixed-point binary to ASCII decimal printer.
//
// Each input beat carries a signed 32-bit value and a scale code; the block
// answers with its decimal string, one ASCII character per output beat, with
// tlast on the final character. Scale codes 0xFF down to 0xFB give one to five
// fractional digits, any other code none; zero always prints as "0". One value
// is handled at a time: the accept state, the shift-and-add-3 BCD converter
// over all 32 bits, a set-up state and then one character per cycle (1 to 12
// characters) while the output is not stalled. The next value is taken while
// the last character still waits in the output register.
module scaled_int_to_decimal_ascii
    import sitoa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // value [31:0], scale_code [39:32]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // char_code [5:0], zero [7:6]
    output logic                 m_tlast
);

    dp_cmd_t           cmd;
    dp_status_t        status;
    logic [CHAR_W-1:0] char_code;

    sitoa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sitoa_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .value      (s_tdata[VALUE_W-1:0]),
        .scale_code (s_tdata[VALUE_W +: SCALE_W]),
        .cmd        (cmd),
        .status     (status),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .char_code  (char_code),
        .char_last  (m_tlast)
    );

    assign m_tdata = {{(M_TDATA_W-CHAR_W){1'b0}}, char_code};

endmodule

// ----- hw/rtl/sitoa_ctrl.sv -----
// Control state machine: accept, convert, set up and emit characters.
module sitoa_ctrl
    import sitoa_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_CONV;
            end
            ST_CONV: begin
                if (status.conv_done) state_next = ST_SETUP;
            end
            ST_SETUP: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free && status.emit_last) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.conv_step = 1'b0;
        cmd.setup     = 1'b0;
        cmd.emit_step = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_CONV:  cmd.conv_step = 1'b1;
            ST_SETUP: cmd.setup = 1'b1;
            ST_EMIT:  cmd.emit_step = status.out_free;
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/sitoa_dp.sv -----
// Datapath: shift-and-add-3 binary to BCD converter and character sequencer.
module sitoa_dp
    import sitoa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [VALUE_W-1:0]   value,
    input  logic [SCALE_W-1:0]   scale_code,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [CHAR_W-1:0]    char_code,
    output logic                 char_last
);

    logic [VALUE_W-1:0] bin_reg;
    logic [BCD_W-1:0]   bcd_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               neg_reg;
    logic [FRAC_W-1:0]  frac_reg;
    logic [POS_W-1:0]   pos_reg;
    logic               sign_pend_reg;
    logic               point_pend_reg;
    logic               m_valid_reg;
    logic [CHAR_W-1:0]  m_char_reg;
    logic               m_last_reg;

    logic [VALUE_W-1:0] mag;
    logic [BCD_W-1:0]   bcd_adj;
    logic [3:0]         digit [NUM_DIGITS];
    logic [POS_W-1:0]   num_dig;
    logic [POS_W-1:0]   total;
    logic [POS_W-1:0]   frac_ext;
    logic [CHAR_W-1:0]  char_next;

    assign mag = value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            digit[i] = bcd_reg[4*i +: 4];
            bcd_adj[4*i +: 4] = (digit[i] >= 4'd5) ? (digit[i] + 4'd3) : digit[i];
        end
    end

    // Count of significant digits, at least one.
    always_comb begin
        num_dig = POS_W'(1);
        for (int i = 1; i < NUM_DIGITS; i++) begin
            if (digit[i] != 4'd0) num_dig = POS_W'(i + 1);
        end
    end

    assign frac_ext = POS_W'(frac_reg);
    assign total = (num_dig > frac_ext) ? num_dig : (frac_ext + POS_W'(1));

    assign status.conv_done = (step_reg == LAST_STEP);
    assign status.out_free  = !m_valid_reg || m_tready;
    assign status.emit_last = !sign_pend_reg && !point_pend_reg && (pos_reg == '0);

    always_comb begin
        if (sign_pend_reg) begin
            char_next = CHAR_MINUS;
        end else if (point_pend_reg) begin
            char_next = CHAR_POINT;
        end else begin
            char_next = CHAR_ZERO + CHAR_W'(digit[pos_reg]);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            bin_reg  <= mag;
            bcd_reg  <= '0;
            step_reg <= '0;
            neg_reg  <= value[VALUE_W-1];
            frac_reg <= (value == '0) ? FRAC_W'(0) : frac_digits(scale_code);
        end else if (cmd.conv_step) begin
            {bcd_reg, bin_reg} <= {bcd_adj[BCD_W-2:0], bin_reg, 1'b0};
            step_reg <= step_reg + STEP_W'(1);
        end

        if (cmd.setup) begin
            pos_reg        <= total - POS_W'(1);
            sign_pend_reg  <= neg_reg;
            point_pend_reg <= 1'b0;
        end else if (cmd.emit_step) begin
            if (sign_pend_reg) begin
                sign_pend_reg <= 1'b0;
            end else if (point_pend_reg) begin
                point_pend_reg <= 1'b0;
            end else begin
                point_pend_reg <= (frac_reg != '0) && (pos_reg == frac_ext);
                if (pos_reg != '0) pos_reg <= pos_reg - POS_W'(1);
            end
        end

        if (cmd.emit_step) begin
            m_char_reg <= char_next;
            m_last_reg <= status.emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_step) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid  = m_valid_reg;
    assign char_code = m_char_reg;
    assign char_last = m_last_reg;

endmodule
